// ----- hdl/ipv4_header_parser_with_payload_match_macros.svh -----
// Assertion helpers shared by the parser modules
`ifndef IPV4_HEADER_PARSER_WITH_PAYLOAD_MATCH_MACROS_SVH
`define IPV4_HEADER_PARSER_WITH_PAYLOAD_MATCH_MACROS_SVH
`ifndef SYNTHESIS
`define IHP_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define IHP_ASSERT_R(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define IHP_ASSERT(label, clk_s, rst_s, prop, msg)
`define IHP_ASSERT_R(label, clk_s, prop, msg)
`endif
`endif

// ----- hdl/ihp_pkg.sv -----
`default_nettype none
package ihp_pkg;

  localparam int PatternMax = 16;
  localparam int PositionBits = 16;
  localparam int FillBits = $clog2(PatternMax + 1);
  localparam logic [PositionBits-1:0] PosMax = {PositionBits{1'b1}};
  localparam int QueueDepth = 2;

  // verdict codes
  localparam logic [1:0] VerdictPass = 2'd0;
  localparam logic [1:0] VerdictBadIp = 2'd1;
  localparam logic [1:0] VerdictBadTcp = 2'd2;
  localparam logic [1:0] VerdictNoMatch = 2'd3;

  // transport classes
  localparam logic [1:0] ClassTcp = 2'd0;
  localparam logic [1:0] ClassUdp = 2'd1;
  localparam logic [1:0] ClassIcmp = 2'd2;
  localparam logic [1:0] ClassOther = 2'd3;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [7:0] ProtoIcmp = 8'd1;

  // register indexes
  localparam logic [1:0] RegPatternFirst = 2'd0;
  localparam logic [1:0] RegPatternLast = 2'd1;
  localparam logic [1:0] RegPatternLength = 2'd2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] ether_kind;
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [1:0]  transport_class;
    logic [7:0]  ip_protocol_number;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_length;
  } out_item_t;

  // classified byte from the front part to the search part
  typedef struct packed {
    logic [7:0] mapped;
    logic       is_zero;
    logic       in_payload;
    logic       last;
    out_item_t  hdr;
  } job_t;

  function automatic logic [1:0] class_of(input logic [7:0] proto);
    logic [1:0] c;
    c = ClassOther;
    if (proto == ProtoTcp) c = ClassTcp;
    else if (proto == ProtoUdp) c = ClassUdp;
    else if (proto == ProtoIcmp) c = ClassIcmp;
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ihp_front.sv -----
`default_nettype none
// Header capture and byte classification
module ihp_front import ihp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     take,
  input  wire in_item_t item,
  output job_t          job
);

  logic [PositionBits-1:0] pos;
  logic [47:0] dmac, smac, dmac_next, smac_next;
  logic [15:0] etype, tot_len, sport, dport;
  logic [15:0] etype_next, tot_len_next, sport_next, dport_next;
  logic [7:0] proto, ihl4, tcp4, proto_next, ihl4_next, tcp4_next;
  logic [31:0] sip, dip, sip_next, dip_next;
  logic [7:0] b;
  logic active;

  // transport start and payload arithmetic
  logic [1:0] cls;
  logic [7:0] thdr;
  logic [16:0] hdr_sum, tp_start;
  logic [16:0] pay_len;
  logic [16:0] t_off, p_off;
  logic ip_ok, tcp_ok;

  // header view once this byte is taken in, used for the frame's last byte
  logic [1:0] cls_next, verd_next;
  logic [7:0] thdr_next;
  logic [16:0] hdr_sum_next, pay_len_next;

  always_comb begin
    b = item.frame_byte;
    active = (pos != PosMax);
    cls = class_of(proto);
    case (cls)
      ClassTcp: thdr = tcp4;
      ClassOther: thdr = 8'd0;
      default: thdr = 8'd8;
    endcase
    hdr_sum = 17'(ihl4) + 17'(thdr);
    pay_len = (17'(tot_len) > hdr_sum) ? 17'(tot_len) - hdr_sum : 17'd0;
    tp_start = 17'd14 + 17'(ihl4);
    t_off = 17'(pos) - tp_start;
    p_off = t_off - 17'(thdr);
    ip_ok = (ihl4 >= 8'd20);
    tcp_ok = !(proto == ProtoTcp && tcp4 < 8'd20);
  end

  // capture of the current byte
  always_comb begin
    dmac_next = dmac; smac_next = smac; etype_next = etype; tot_len_next = tot_len;
    proto_next = proto; ihl4_next = ihl4; tcp4_next = tcp4; sip_next = sip;
    dip_next = dip; sport_next = sport; dport_next = dport;
    if (active) begin
      if (pos < 6) dmac_next = {dmac[39:0], b};
      else if (pos < 12) smac_next = {smac[39:0], b};
      else if (pos < 14) etype_next = {etype[7:0], b};
      else if (pos == 14) ihl4_next = {2'b00, b[3:0], 2'b00};
      else if (pos == 16 || pos == 17) tot_len_next = {tot_len[7:0], b};
      else if (pos == 23) proto_next = b;
      else if (pos >= 26 && pos < 30) sip_next = {sip[23:0], b};
      else if (pos >= 30 && pos < 34) dip_next = {dip[23:0], b};
      if (ip_ok && 17'(pos) >= tp_start) begin
        if (cls <= ClassUdp && t_off < 17'd2) sport_next = {sport[7:0], b};
        else if (cls <= ClassUdp && t_off < 17'd4) dport_next = {dport[7:0], b};
        else if (cls == ClassTcp && t_off == 17'd12) tcp4_next = {2'b00, b[7:4], 2'b00};
      end
    end
  end

  // header checks and payload length after the byte
  always_comb begin
    cls_next = class_of(proto_next);
    case (cls_next)
      ClassTcp: thdr_next = tcp4_next;
      ClassOther: thdr_next = 8'd0;
      default: thdr_next = 8'd8;
    endcase
    hdr_sum_next = 17'(ihl4_next) + 17'(thdr_next);
    pay_len_next = (17'(tot_len_next) > hdr_sum_next) ? 17'(tot_len_next) - hdr_sum_next
                                                       : 17'd0;
    if (ihl4_next < 8'd20) verd_next = VerdictBadIp;
    else if (proto_next == ProtoTcp && tcp4_next < 8'd20) verd_next = VerdictBadTcp;
    else verd_next = VerdictPass;
  end

  // payload flag and mapping use the state before this byte
  always_comb begin
    job.in_payload = active && ip_ok && tcp_ok && 17'(pos) >= tp_start + 17'(thdr)
                     && p_off < pay_len;
    job.is_zero = (b == 8'd0);
    job.mapped = (b < 8'h20 || b > 8'h7e) ? 8'd27 : b;
    job.last = item.frame_end;
    job.hdr.verdict = verd_next;
    job.hdr.ether_kind = etype_next;
    job.hdr.source_mac = smac_next;
    job.hdr.dest_mac = dmac_next;
    job.hdr.transport_class = cls_next;
    job.hdr.ip_protocol_number = proto_next;
    job.hdr.source_ip = sip_next;
    job.hdr.dest_ip = dip_next;
    job.hdr.source_port = (verd_next == VerdictBadIp) ? 16'd0 : sport_next;
    job.hdr.dest_port = (verd_next == VerdictBadIp) ? 16'd0 : dport_next;
    job.hdr.payload_length = (verd_next == VerdictPass) ? pay_len_next[15:0] : 16'd0;
  end

  // capture registers
  always_ff @(posedge clk) begin
    if (rst || (take && item.frame_end)) begin
      pos <= '0; dmac <= '0; smac <= '0; etype <= '0; tot_len <= '0;
      proto <= '0; ihl4 <= '0; tcp4 <= '0; sip <= '0; dip <= '0;
      sport <= '0; dport <= '0;
    end else if (take && active) begin
      pos <= pos + 1'b1;
      dmac <= dmac_next; smac <= smac_next; etype <= etype_next;
      tot_len <= tot_len_next; proto <= proto_next; ihl4 <= ihl4_next;
      tcp4 <= tcp4_next; sip <= sip_next; dip <= dip_next;
      sport <= sport_next; dport <= dport_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ihp_queue.sv -----
`default_nettype none
`include "ipv4_header_parser_with_payload_match_macros.svh"
// Short job queue between front and back parts
module ihp_queue import ihp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  job_t      wdata,
  output logic      full,
  input  wire logic rd,
  output logic      empty,
  output job_t      rdata
);

  localparam int AW = $clog2(QueueDepth);
  job_t slots [QueueDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign full = (cnt == (AW+1)'(QueueDepth));
  assign empty = (cnt == '0);
  assign rdata = slots[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) slots[wp] <= wdata;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr && !full) wp <= wp + 1'b1;
      if (rd && !empty) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

  `IHP_ASSERT(a_cnt_range, clk, rst, cnt <= (AW+1)'(QueueDepth), "queue count overflow")
  `IHP_ASSERT(a_no_underflow, clk, rst, empty |-> !(rd && !empty), "queue underflow")
  `IHP_ASSERT_R(a_reset_empty, clk, $past(rst) |-> empty, "queue not empty after reset")

endmodule
`default_nettype wire

// ----- hdl/ihp_back.sv -----
`default_nettype none
`include "ipv4_header_parser_with_payload_match_macros.svh"
// Sliding pattern search and verdict
module ihp_back import ihp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         job_valid,
  input  job_t              job,
  output logic              job_take,
  input  wire logic [63:0]  pat_lo,
  input  wire logic [63:0]  pat_hi,
  input  wire logic [4:0]   pat_len,
  output logic              res_valid,
  output out_item_t         res,
  input  wire logic         res_take
);

  logic [7:0] win [PatternMax];
  logic [7:0] win_new [PatternMax];
  logic [7:0] pbyte [PatternMax];
  logic [FillBits-1:0] fill, fill_new, elen;
  logic closed, seen, hit, do_byte, closing;
  logic [1:0] verd;
  out_item_t res_next;

  always_comb begin
    for (int i = 0; i < PatternMax; i++)
      pbyte[i] = (i < 8) ? pat_lo[8*(i%8) +: 8] : pat_hi[8*(i%8) +: 8];
    // effective length: capped, stops at first zero byte
    elen = (pat_len > 5'(PatternMax)) ? FillBits'(PatternMax) : FillBits'(pat_len);
    for (int i = PatternMax - 1; i >= 0; i--)
      if (pbyte[i] == 8'd0 && FillBits'(i) < elen) elen = FillBits'(i);
    do_byte = job.in_payload && !closed && !job.is_zero;
    closing = job.in_payload && !closed && job.is_zero;
    for (int i = 0; i < PatternMax - 1; i++) win_new[i] = win[i+1];
    win_new[PatternMax-1] = job.mapped;
    fill_new = (fill < FillBits'(PatternMax)) ? fill + 1'b1 : fill;
    hit = (elen != '0) && (fill_new >= elen);
    for (int i = 0; i < PatternMax; i++)
      if (FillBits'(i) < elen && win_new[PatternMax - int'(elen) + i] != pbyte[i]) hit = 1'b0;
  end

  assign job_take = job_valid && (!res_valid || res_take || !job.last);

  // final verdict for the frame's last byte; header faults take precedence
  always_comb begin
    verd = job.hdr.verdict;
    if (verd == VerdictPass && elen != '0 && !(seen || (do_byte && hit)))
      verd = VerdictNoMatch;
    res_next = job.hdr;
    res_next.verdict = verd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0; closed <= 1'b0; seen <= 1'b0; res_valid <= 1'b0;
    end else begin
      if (res_take) res_valid <= 1'b0;
      if (job_take) begin
        if (job.last) begin
          fill <= '0; closed <= 1'b0; seen <= 1'b0;
          res_valid <= 1'b1;
        end else begin
          if (do_byte) begin
            fill <= fill_new;
            if (hit) seen <= 1'b1;
          end
          if (closing) closed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (job_take && job.last)) begin
      for (int i = 0; i < PatternMax; i++) win[i] <= '0;
    end else if (job_take && do_byte) begin
      for (int i = 0; i < PatternMax; i++) win[i] <= win_new[i];
    end
    if (job_take && job.last) res <= res_next;
  end

  `IHP_ASSERT(a_fill_cap, clk, rst, fill <= FillBits'(PatternMax), "window fill overflow")
  `IHP_ASSERT(a_no_overwrite, clk, rst,
    (res_valid && !res_take) |=> $stable(res), "pending result overwritten")

endmodule
`default_nettype wire

// ----- hdl/ipv4_header_parser_with_payload_match.sv -----
`default_nettype none
// Ethernet/IPv4 header parser with payload pattern filter.
// Input queue side: frame_in (byte, end flag) is taken when push && !full.
// Result queue side: result is valid while empty is low, removed by pop.
// One result per frame, produced from the frame's last byte.
// The front part captures headers and classifies each byte in the cycle it
// arrives; a two-entry job queue feeds the search part, which keeps a
// 16-byte sliding window compared in parallel and registers the result.
// Throughput: one byte per cycle while pop keeps up; the result is registered
// once the frame's last byte leaves the job queue.
// Bad headers are reported on the verdict field after the whole frame.
// When pop is held low the result register holds; bytes of the next frame
// still flow, its last byte waits at the queue head and full rises once one
// more byte sits behind it. Reset clears all frame state, the queue and the
// pattern registers. Pattern registers sit on an APB port at byte addresses
// 0, 8 and 16; change them only when the block is idle.
module ipv4_header_parser_with_payload_match import ihp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  in_item_t         frame_in,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] pat_lo, pat_hi;
  logic [4:0] pat_len;
  logic [1:0] reg_idx;
  job_t fjob, qjob;
  logic q_empty, job_take, res_valid;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo <= '0; pat_hi <= '0; pat_len <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegPatternFirst: pat_lo <= pwdata;
        RegPatternLast: pat_hi <= pwdata;
        RegPatternLength: pat_len <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPatternFirst: prdata = pat_lo;
      RegPatternLast: prdata = pat_hi;
      RegPatternLength: prdata = {59'd0, pat_len};
      default: prdata = '0;
    endcase
  end

  ihp_front u_front (
    .clk(clk), .rst(rst), .take(push && !full), .item(frame_in), .job(fjob)
  );

  ihp_queue u_queue (
    .clk(clk), .rst(rst), .wr(push), .wdata(fjob), .full(full),
    .rd(job_take), .empty(q_empty), .rdata(qjob)
  );

  ihp_back u_back (
    .clk(clk), .rst(rst), .job_valid(!q_empty), .job(qjob), .job_take(job_take),
    .pat_lo(pat_lo), .pat_hi(pat_hi), .pat_len(pat_len),
    .res_valid(res_valid), .res(result), .res_take(pop)
  );

  assign empty = !res_valid;

endmodule
`default_nettype wire

// ----- tb/ipv4_header_parser_with_payload_match_tb.sv -----
`timescale 1ns / 1ps

module ipv4_header_parser_with_payload_match_tb;
  import ihp_pkg::*;

  // Predicts parser verdicts and holds the results still owed by the block
  class verdict_board;
    logic [63:0] pat_lo, pat_hi;
    logic [4:0]  pat_len;
    logic [15:0] pos;
    logic [47:0] dmac, smac;
    logic [15:0] etype, tot_len, sport, dport;
    logic [7:0]  proto, ihl_bytes, tcp_bytes;
    logic [31:0] sip, dip;
    logic [7:0]  win [PatternMax];
    int          fill;
    bit          closed, seen;
    out_item_t   owed [$];
    int          errors;

    function void set_reg(int idx, logic [63:0] v);
      if (idx == RegPatternFirst) pat_lo = v;
      else if (idx == RegPatternLast) pat_hi = v;
      else if (idx == RegPatternLength) pat_len = v[4:0];
    endfunction

    function void clear_frame();
      pos = 0; dmac = 0; smac = 0; etype = 0; tot_len = 0; proto = 0;
      sip = 0; dip = 0; sport = 0; dport = 0; ihl_bytes = 0; tcp_bytes = 0;
      fill = 0; closed = 0; seen = 0;
      foreach (win[i]) win[i] = 0;
    endfunction

    function void reset_all();
      pat_lo = 0; pat_hi = 0; pat_len = 0; errors = 0;
      owed.delete();
      clear_frame();
    endfunction

    function logic [7:0] pat_byte(int i);
      return i < 8 ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
    endfunction

    // pattern length after clamping and cut at the first zero byte
    function int pat_in_use();
      int n;
      n = pat_len > PatternMax ? PatternMax : pat_len;
      for (int i = 0; i < n; i++) if (pat_byte(i) == 0) return i;
      return n;
    endfunction

    function logic [1:0] cls();
      case (proto)
        ProtoTcp:  return ClassTcp;
        ProtoUdp:  return ClassUdp;
        ProtoIcmp: return ClassIcmp;
        default:   return ClassOther;
      endcase
    endfunction

    function int trans_bytes();
      if (cls() == ClassTcp) return tcp_bytes;
      if (cls() == ClassOther) return 0;
      return 8;
    endfunction

    function int pay_len();
      int h;
      h = ihl_bytes + trans_bytes();
      return tot_len > h ? tot_len - h : 0;
    endfunction

    function bit hdr_ok();
      return !(ihl_bytes < 20 || (proto == ProtoTcp && tcp_bytes < 20));
    endfunction

    function void capture(int p, logic [7:0] b);
      int ihl, t;
      ihl = ihl_bytes;
      if (p < 6) dmac = {dmac[39:0], b};
      else if (p < 12) smac = {smac[39:0], b};
      else if (p < 14) etype = {etype[7:0], b};
      else if (p == 14) ihl_bytes = {2'b0, b[3:0], 2'b0};
      else if (p == 16 || p == 17) tot_len = {tot_len[7:0], b};
      else if (p == 23) proto = b;
      else if (p >= 26 && p < 30) sip = {sip[23:0], b};
      else if (p >= 30 && p < 34) dip = {dip[23:0], b};
      if (ihl >= 20 && p >= 14 + ihl) begin
        t = p - (14 + ihl);
        if (cls() <= ClassUdp && t < 2) sport = {sport[7:0], b};
        else if (cls() <= ClassUdp && t < 4) dport = {dport[7:0], b};
        else if (cls() == ClassTcp && t == 12) tcp_bytes = {2'b0, b[7:4], 2'b0};
      end
    endfunction

    function void scan(int p, logic [7:0] b);
      int st, n;
      bit ok;
      if (closed || !hdr_ok()) return;
      st = 14 + ihl_bytes + trans_bytes();
      if (p < st || p - st >= pay_len()) return;
      if (b == 0) begin
        closed = 1;
        return;
      end
      if (b < 8'h20 || b > 8'h7e) b = 8'd27;
      for (int i = 0; i < PatternMax - 1; i++) win[i] = win[i+1];
      win[PatternMax-1] = b;
      if (fill < PatternMax) fill++;
      n = pat_in_use();
      if (n == 0 || fill < n) return;
      ok = 1;
      for (int i = 0; i < n; i++) if (win[PatternMax-n+i] != pat_byte(i)) ok = 0;
      if (ok) seen = 1;
    endfunction

    // note one accepted request
    function void note_byte(in_item_t it);
      out_item_t r;
      if (pos < PosMax) begin
        capture(pos, it.frame_byte);
        scan(pos, it.frame_byte);
        pos++;
      end
      if (!it.frame_end) return;
      if (ihl_bytes < 20) r.verdict = VerdictBadIp;
      else if (proto == ProtoTcp && tcp_bytes < 20) r.verdict = VerdictBadTcp;
      else if (pat_in_use() > 0 && !seen) r.verdict = VerdictNoMatch;
      else r.verdict = VerdictPass;
      r.ether_kind = etype; r.source_mac = smac; r.dest_mac = dmac;
      r.transport_class = cls(); r.ip_protocol_number = proto;
      r.source_ip = sip; r.dest_ip = dip;
      r.source_port = r.verdict == VerdictBadIp ? 16'd0 : sport;
      r.dest_port = r.verdict == VerdictBadIp ? 16'd0 : dport;
      r.payload_length = (r.verdict == VerdictBadIp || r.verdict == VerdictBadTcp)
                         ? 16'd0 : 16'(pay_len());
      owed.push_back(r);
      clear_frame();
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = owed.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch");
          $display("  exp %h", exp);
          $display("  got %h", got);
        end
      end
    endfunction
  endclass

  logic        clk, rst, push, pop, psel, penable, pwrite;
  logic        full, empty, pready;
  in_item_t    frame_in;
  out_item_t   result;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;

  verdict_board board;
  int cycles;
  bit hold_rx, sending;
  byte unsigned fbuf [$];

  ipv4_header_parser_with_payload_match uut (
    .clk, .rst, .push, .full, .frame_in, .empty, .pop, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // scoreboard taps on the handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) board.note_byte(frame_in);
      if (pop && !empty) board.check_result(result);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : drain
    int w;
    pop = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (1000) @(posedge clk);
        hold_rx = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        pop <= 1'b0;
        repeat (w) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  task automatic reg_write(int idx, logic [63:0] v);
    paddr <= 5'(8 * idx); pwdata <= v; pwrite <= 1'b1;
    psel <= 1'b1; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.set_reg(idx, v);
  endtask

  task automatic set_pattern(logic [63:0] lo, logic [63:0] hi, logic [4:0] n);
    reg_write(RegPatternFirst, lo);
    reg_write(RegPatternLast, hi);
    reg_write(RegPatternLength, 64'(n));
  endtask

  // send one byte, honouring full; gaps drawn per request
  task automatic send_byte(logic [7:0] b, logic e, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 5) : 0;
    if (w > 0) begin
      push <= 1'b0;
      repeat (w) @(posedge clk);
    end
    push <= 1'b1;
    frame_in <= '{frame_byte: b, frame_end: e};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_frame(bit gaps);
    foreach (fbuf[i]) send_byte(fbuf[i], i == fbuf.size() - 1, gaps);
    fbuf.delete();
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // builds a frame into fbuf from the given header fields, optionally planting the pattern
  task automatic build_frame(int pr, int ihl, int doff, int plen, bit plant);
    int hl, tl, len;
    byte unsigned pb;
    fbuf.delete();
    for (int i = 0; i < 12; i++) fbuf.push_back(8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      fbuf.push_back(8'h08); fbuf.push_back(8'h06);
    end else begin
      fbuf.push_back(8'h08); fbuf.push_back(8'h00);
    end
    hl = pr == ProtoTcp ? doff * 4 : (pr == ProtoUdp || pr == ProtoIcmp) ? 8 : 0;
    tl = ihl * 4 + hl + plen;
    if ($urandom_range(0, 7) == 0) tl = $urandom_range(0, 80);
    fbuf.push_back(8'h40 | ihl[3:0]);
    fbuf.push_back(8'($urandom));
    fbuf.push_back(tl[15:8]); fbuf.push_back(tl[7:0]);
    for (int i = 0; i < 5; i++) fbuf.push_back(8'($urandom));
    fbuf.push_back(pr[7:0]);
    for (int i = 0; i < 10; i++) fbuf.push_back(8'($urandom));
    for (int i = 20; i < ihl * 4; i++) fbuf.push_back(8'($urandom));
    for (int i = 0; i < hl; i++)
      fbuf.push_back(i == 12 ? {doff[3:0], 4'($urandom)} : 8'($urandom));
    len = board.pat_in_use();
    for (int i = 0; i < plen; i++) begin
      case ($urandom_range(0, 9))
        0: pb = 8'($urandom);
        1: pb = 0;
        default: pb = 8'($urandom_range(8'h20, 8'h7e));
      endcase
      if (plant && len > 0 && i >= plen - len - 1 && i < plen - 1) begin
        pb = board.pat_byte(i - (plen - len - 1));
        if (pb < 8'h20 || pb > 8'h7e) pb = 8'h41;
      end
      fbuf.push_back(pb);
    end
    len = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) fbuf.push_back(8'($urandom));
  endtask

  function automatic int pick_proto();
    case ($urandom_range(0, 5))
      0, 1: return ProtoTcp;
      2, 3: return ProtoUdp;
      4: return ProtoIcmp;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_frames(int n);
    int pr, doff;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        int len;
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) fbuf.push_back(8'($urandom));
      end else begin
        pr = pick_proto();
        doff = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4) : $urandom_range(5, 7);
        build_frame(pr, $urandom_range(0, 9) == 0 ? $urandom_range(0, 15)
                        : $urandom_range(5, 6),
                    doff, $urandom_range(0, 20), $urandom_range(0, 1));
      end
      send_frame($urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    board = new();
    board.reset_all();
    rst = 1'b1; push = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; frame_in = '0; hold_rx = 0; cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: filter off, field extremes and the special cases
    set_pattern(64'h0, 64'h0, 5'd0);
    fbuf = {8'hff}; send_frame(0);
    fbuf = {8'h00, 8'hff, 8'h00}; send_frame(0);
    for (int i = 0; i < 40; i++) fbuf.push_back(8'hff);
    send_frame(0);
    for (int i = 0; i < 40; i++) fbuf.push_back(8'h00);
    send_frame(0);
    build_frame(ProtoTcp, 5, 5, 6, 0); send_frame(0);
    build_frame(ProtoTcp, 5, 3, 6, 0); send_frame(0);
    build_frame(ProtoUdp, 15, 0, 4, 0); send_frame(0);
    build_frame(ProtoIcmp, 4, 0, 4, 0); send_frame(0);
    build_frame(99, 5, 0, 4, 0); send_frame(0);
    wait_idle();

    // three byte pattern, then empty payload and a length-clamped pattern
    set_pattern(64'h0000_0000_0063_6261, 64'h0, 5'd3);
    build_frame(ProtoUdp, 5, 0, 12, 1); send_frame(0);
    build_frame(ProtoTcp, 6, 6, 12, 1); send_frame(0);
    build_frame(ProtoUdp, 5, 0, 0, 0); send_frame(0);
    wait_idle();
    set_pattern(64'h7e7e_7e7e_7e7e_7e7e, 64'hffff_ffff_ffff_ffff, 5'd31);
    build_frame(ProtoUdp, 5, 0, 20, 1); send_frame(0);
    wait_idle();
    set_pattern(64'h2020_2020_2020_2020, 64'h2020_2020_2020_2020, 5'd16);
    build_frame(ProtoUdp, 5, 0, 20, 1); send_frame(0);
    wait_idle();

    // random phases over several pattern settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_pattern(64'h0, 64'h0, 5'd0);
        1: set_pattern(64'h0000_0000_0000_4141, 64'h0, 5'd2);
        2: set_pattern({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom));
        3: set_pattern(64'h1b, 64'h0, 5'd1);
        4: set_pattern(64'h4847_4645_4443_4241, 64'h504f_4e4d_4c4b_4a49, 5'd16);
        default: set_pattern(64'h0000_0000_3e3d_3c3b, 64'h0, 5'd4);
      endcase
      if (ph == 2) hold_rx = 1;
      random_frames(4);
      wait_idle();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ihp_pkg.sv
hdl/ihp_front.sv
hdl/ihp_queue.sv
hdl/ihp_back.sv
hdl/ipv4_header_parser_with_payload_match.sv
tb/ipv4_header_parser_with_payload_match_tb.sv
